FILE: sv/fcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcd_pkg
// Shared types and constants of the framed command deframer.
// ----------------------------------------------------------------------------
package fcd_pkg;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEADER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_LIMIT = 2'd1;

    localparam logic [15:0] FRAME_HEADER_RST = 16'hAA55;
    localparam logic [5:0] PAYLOAD_LIMIT_RST = 6'd32;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_TRUNC    = 3'd1,
        ST_HEADER   = 3'd2,
        ST_LENGTH   = 3'd3,
        ST_CHECKSUM = 3'd4
    } status_t;

    typedef struct packed {
        logic    hdr_hi_ld;
        logic    len_hi_ld;
        logic    len_ld;
        logic    type_ld;
        logic    csum_hi_ld;
        logic    sum_add;
        logic    restart;
        logic    pos_clr;
        logic    pay_wr;
        logic    emit_clr;
        logic    rd_issue;
        logic    ld_byte;
        logic    ld_status;
        logic    with_type;
        status_t status_code;
    } fcd_cmd_t;

    typedef struct packed {
        logic hdr_match;
        logic len_over;
        logic len_zero;
        logic pay_last;
        logic csum_ok;
        logic rd_pend;
        logic rd_more;
        logic out_free;
    } fcd_stat_t;

endpackage

FILE: sv/framed_command_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framed_command_deframer
// Parses header, length, type, payload and sum16 checksum from a byte stream
// and emits the payload bytes or a single status request.
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  in       sink       in_valid / in_ready    data_byte, buffer_end
//  out      source     out_valid / out_ready  status, cmd_type, byte_count,
//                                             payload_byte, byte_index,
//                                             has_byte, last_result
//  cfg      sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  One input byte per cycle while parsing, held back only while the result
//  register is occupied and not being taken.
//  A good frame with a payload is emitted from the registered-read payload RAM
//  at one byte per cycle while the result register is free; input is held off for the whole burst.
//  Reset clears the parser to await the header and restores both registers;
//  the payload RAM needs no clearing. cfg_ready is always high.
// ----------------------------------------------------------------------------
module framed_command_deframer
    import fcd_pkg::*;
#(
    parameter int MAX_PAYLOAD = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            data_byte,
    input  logic                  buffer_end,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [2:0]            status,
    output logic [7:0]            cmd_type,
    output logic [5:0]            byte_count,
    output logic [7:0]            payload_byte,
    output logic [4:0]            byte_index,
    output logic                  has_byte,
    output logic                  last_result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    fcd_cmd_t  cmd;
    fcd_stat_t stat;

    assign cfg_ready = 1'b1;

    fcd_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .buffer_end (buffer_end),
        .stat       (stat),
        .cmd        (cmd)
    );

    fcd_dp #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .data_byte    (data_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .cmd_type     (cmd_type),
        .byte_count   (byte_count),
        .payload_byte (payload_byte),
        .byte_index   (byte_index),
        .has_byte     (has_byte),
        .last_result  (last_result)
    );

endmodule

FILE: sv/fcd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcd_ram
// Generic simple dual-port RAM with registered read.
// ----------------------------------------------------------------------------
module fcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/fcd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcd_ctrl
// Frame parsing state machine; issues commands to the datapath.
// ----------------------------------------------------------------------------
module fcd_ctrl
    import fcd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  logic      buffer_end,
    input  fcd_stat_t stat,
    output fcd_cmd_t  cmd
);

    typedef enum logic [9:0] {
        S_HDR0  = 10'b00_0000_0001,
        S_HDR1  = 10'b00_0000_0010,
        S_LEN0  = 10'b00_0000_0100,
        S_LEN1  = 10'b00_0000_1000,
        S_TYPE  = 10'b00_0001_0000,
        S_PAY   = 10'b00_0010_0000,
        S_CSUM0 = 10'b00_0100_0000,
        S_CSUM1 = 10'b00_1000_0000,
        S_SKIP  = 10'b01_0000_0000,
        S_EMIT  = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   ret_hdr_reg, ret_hdr_next;
    logic   in_fire;
    logic   done;

    assign in_ready = (state_reg != S_EMIT) && stat.out_free;
    assign in_fire = in_valid && in_ready;

    always_comb
    begin
        cmd = '0;
        cmd.status_code = ST_OK;
        state_next = state_reg;
        ret_hdr_next = ret_hdr_reg;
        done = 1'b0;
        if (in_fire)
        begin
            case (state_reg)
                S_HDR0:
                begin
                    cmd.hdr_hi_ld = 1'b1;
                    cmd.sum_add = 1'b1;
                    state_next = S_HDR1;
                end
                S_HDR1:
                begin
                    cmd.sum_add = 1'b1;
                    if (stat.hdr_match)
                    begin
                        state_next = S_LEN0;
                    end
                    else
                    begin
                        cmd.ld_status = 1'b1;
                        cmd.status_code = ST_HEADER;
                        done = 1'b1;
                        state_next = S_SKIP;
                    end
                end
                S_LEN0:
                begin
                    cmd.len_hi_ld = 1'b1;
                    cmd.sum_add = 1'b1;
                    state_next = S_LEN1;
                end
                S_LEN1:
                begin
                    cmd.sum_add = 1'b1;
                    if (stat.len_over)
                    begin
                        cmd.ld_status = 1'b1;
                        cmd.status_code = ST_LENGTH;
                        done = 1'b1;
                        state_next = S_SKIP;
                    end
                    else
                    begin
                        cmd.len_ld = 1'b1;
                        state_next = S_TYPE;
                    end
                end
                S_TYPE:
                begin
                    cmd.type_ld = 1'b1;
                    cmd.sum_add = 1'b1;
                    cmd.pos_clr = 1'b1;
                    state_next = stat.len_zero ? S_CSUM0 : S_PAY;
                end
                S_PAY:
                begin
                    cmd.sum_add = 1'b1;
                    cmd.pay_wr = 1'b1;
                    if (stat.pay_last)
                    begin
                        state_next = S_CSUM0;
                    end
                end
                S_CSUM0:
                begin
                    cmd.csum_hi_ld = 1'b1;
                    state_next = S_CSUM1;
                end
                S_CSUM1:
                begin
                    done = 1'b1;
                    if (!stat.csum_ok)
                    begin
                        cmd.ld_status = 1'b1;
                        cmd.status_code = ST_CHECKSUM;
                        state_next = S_SKIP;
                    end
                    else if (stat.len_zero)
                    begin
                        cmd.ld_status = 1'b1;
                        cmd.with_type = 1'b1;
                        cmd.status_code = ST_OK;
                        state_next = S_SKIP;
                    end
                    else
                    begin
                        cmd.emit_clr = 1'b1;
                        ret_hdr_next = buffer_end;
                        state_next = S_EMIT;
                    end
                end
                default:
                begin
                end
            endcase
            // buffer end: report truncation unless the byte closed the frame or the frame was being skipped
            if (buffer_end)
            begin
                if (!done && (state_reg != S_SKIP))
                begin
                    cmd.ld_status = 1'b1;
                    cmd.status_code = ST_TRUNC;
                end
                cmd.restart = 1'b1;
                if (state_next != S_EMIT)
                begin
                    state_next = S_HDR0;
                end
            end
        end
        else if (state_reg == S_EMIT)
        begin
            cmd.ld_byte = stat.rd_pend && stat.out_free;
            cmd.rd_issue = stat.rd_more && (!stat.rd_pend || cmd.ld_byte);
            if (cmd.ld_byte && !stat.rd_more)
            begin
                state_next = ret_hdr_reg ? S_HDR0 : S_SKIP;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_HDR0;
            ret_hdr_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ret_hdr_reg <= ret_hdr_next;
        end
    end

    a_emit_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> !in_ready)
        else $error("input taken during payload emission");

endmodule

FILE: sv/fcd_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcd_dp
// Frame datapath: field registers, checksum, payload store and result register.
// ----------------------------------------------------------------------------
module fcd_dp
    import fcd_pkg::*;
#(
    parameter int MAX_PAYLOAD = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  fcd_cmd_t              cmd,
    output fcd_stat_t             stat,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [7:0]            data_byte,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [2:0]            status,
    output logic [7:0]            cmd_type,
    output logic [5:0]            byte_count,
    output logic [7:0]            payload_byte,
    output logic [4:0]            byte_index,
    output logic                  has_byte,
    output logic                  last_result
);

    localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);
    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam logic [15:0] MAX_LEN = 16'(MAX_PAYLOAD);

    logic [15:0]      frame_header_reg;
    logic [5:0]       payload_limit_reg;
    logic [15:0]      sum_reg, sum_next;
    logic [LEN_W-1:0] pos_reg, pos_next, pos_inc;
    logic [LEN_W-1:0] rd_idx_reg, rd_idx_next;
    logic [LEN_W-1:0] ld_idx_reg, ld_idx_next, ld_idx_inc;
    logic             rd_pend_reg, rd_pend_next;
    logic             out_valid_reg, out_valid_next;

    logic [7:0]       hdr_hi_reg;
    logic [7:0]       len_hi_reg;
    logic [7:0]       csum_hi_reg;
    logic [7:0]       type_reg;
    logic [LEN_W-1:0] len_reg;

    status_t          status_reg;
    logic [7:0]       cmd_type_reg;
    logic [5:0]       byte_count_reg;
    logic [7:0]       payload_byte_reg;
    logic [4:0]       byte_index_reg;
    logic             has_byte_reg;
    logic             last_result_reg;

    logic [15:0]      len_word;
    logic [15:0]      len_ext;
    logic [15:0]      idx_ext;
    logic [7:0]       ram_rdata;
    logic             out_free;

    assign len_word = {len_hi_reg, data_byte};
    assign len_ext = 16'(len_reg);
    assign idx_ext = 16'(ld_idx_reg);
    assign pos_inc = pos_reg + LEN_W'(1);
    assign ld_idx_inc = ld_idx_reg + LEN_W'(1);
    assign out_free = !out_valid_reg || out_ready;

    assign stat.hdr_match = ({hdr_hi_reg, data_byte} == frame_header_reg);
    assign stat.len_over = (len_word > {10'd0, payload_limit_reg}) || (len_word > MAX_LEN);
    assign stat.len_zero = (len_reg == '0);
    assign stat.pay_last = (pos_inc == len_reg);
    assign stat.csum_ok = ({csum_hi_reg, data_byte} == sum_reg);
    assign stat.rd_pend = rd_pend_reg;
    assign stat.rd_more = (rd_idx_reg < len_reg);
    assign stat.out_free = out_free;

    always_comb
    begin
        sum_next = sum_reg;
        if (cmd.restart)
        begin
            sum_next = '0;
        end
        else if (cmd.sum_add)
        begin
            sum_next = sum_reg + {8'd0, data_byte};
        end

        pos_next = pos_reg;
        if (cmd.pos_clr)
        begin
            pos_next = '0;
        end
        else if (cmd.pay_wr)
        begin
            pos_next = pos_inc;
        end

        rd_idx_next = rd_idx_reg;
        ld_idx_next = ld_idx_reg;
        rd_pend_next = rd_pend_reg;
        if (cmd.emit_clr)
        begin
            rd_idx_next = '0;
            ld_idx_next = '0;
            rd_pend_next = 1'b0;
        end
        else
        begin
            if (cmd.rd_issue)
            begin
                rd_idx_next = rd_idx_reg + LEN_W'(1);
            end
            if (cmd.ld_byte)
            begin
                ld_idx_next = ld_idx_inc;
            end
            if (cmd.rd_issue)
            begin
                rd_pend_next = 1'b1;
            end
            else if (cmd.ld_byte)
            begin
                rd_pend_next = 1'b0;
            end
        end

        if (cmd.ld_status || cmd.ld_byte)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_header_reg <= FRAME_HEADER_RST;
            payload_limit_reg <= PAYLOAD_LIMIT_RST;
            sum_reg <= '0;
            pos_reg <= '0;
            rd_idx_reg <= '0;
            ld_idx_reg <= '0;
            rd_pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index == CFG_FRAME_HEADER))
            begin
                frame_header_reg <= cfg_data;
            end
            if (cfg_we && (cfg_index == CFG_PAYLOAD_LIMIT))
            begin
                payload_limit_reg <= cfg_data[5:0];
            end
            sum_reg <= sum_next;
            pos_reg <= pos_next;
            rd_idx_reg <= rd_idx_next;
            ld_idx_reg <= ld_idx_next;
            rd_pend_reg <= rd_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.hdr_hi_ld)
        begin
            hdr_hi_reg <= data_byte;
        end
        if (cmd.len_hi_ld)
        begin
            len_hi_reg <= data_byte;
        end
        if (cmd.len_ld)
        begin
            len_reg <= len_word[LEN_W-1:0];
        end
        if (cmd.type_ld)
        begin
            type_reg <= data_byte;
        end
        if (cmd.csum_hi_ld)
        begin
            csum_hi_reg <= data_byte;
        end
        if (cmd.ld_status)
        begin
            status_reg <= cmd.status_code;
            cmd_type_reg <= cmd.with_type ? type_reg : 8'd0;
            byte_count_reg <= '0;
            payload_byte_reg <= '0;
            byte_index_reg <= '0;
            has_byte_reg <= 1'b0;
            last_result_reg <= 1'b1;
        end
        else if (cmd.ld_byte)
        begin
            status_reg <= ST_OK;
            cmd_type_reg <= type_reg;
            byte_count_reg <= len_ext[5:0];
            payload_byte_reg <= ram_rdata;
            byte_index_reg <= idx_ext[4:0];
            has_byte_reg <= 1'b1;
            last_result_reg <= (ld_idx_inc == len_reg);
        end
    end

    fcd_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PAYLOAD)
    ) u_store (
        .clk   (clk),
        .we    (cmd.pay_wr),
        .waddr (pos_reg[AW-1:0]),
        .wdata (data_byte),
        .re    (cmd.rd_issue),
        .raddr (rd_idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign out_valid = out_valid_reg;
    assign status = status_reg;
    assign cmd_type = cmd_type_reg;
    assign byte_count = byte_count_reg;
    assign payload_byte = payload_byte_reg;
    assign byte_index = byte_index_reg;
    assign has_byte = has_byte_reg;
    assign last_result = last_result_reg;

    a_load_needs_data: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ld_byte |-> (rd_pend_reg && out_free))
        else $error("payload byte loaded without pending read or free slot");

    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_issue |-> (rd_idx_reg < len_reg))
        else $error("store read beyond payload length");

    a_byte_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && has_byte_reg) |-> (status_reg == ST_OK))
        else $error("payload byte with fault status");

endmodule
